// ----- sv/point_in_polygon_ray_crossing_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the point in polygon block
// The checks sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_RAY_CROSSING_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CROSSING_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge.
`define PIP_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pip: invariant violated");
// A condition that, once seen, forces another one on the next edge.
`define PIP_ASSERT_NEXT(name, cause, effect) \
  name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("pip: sequence violated");
`else
`define PIP_ASSERT(name, expr)
`define PIP_ASSERT_NEXT(name, cause, effect)
`endif
`endif

// ----- sv/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants, types and state codes of the point in polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int COORD_BITS    = 16;
  localparam int MIN_VERTICES  = 3;
  localparam int VCOUNT_RESET  = 3;
  localparam int RAY_MARGIN    = 3;

  localparam int IDX_BITS      = $clog2(MAX_VERTICES);
  localparam int VIDX_BITS     = 6;
  localparam int CNT_BITS      = 7;

  // Edge and point differences need one extra bit, the ray vector two.
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int RAY_BITS      = COORD_BITS + 2;
  localparam int PROD_BITS     = DIFF_BITS + RAY_BITS + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Store layout: x in the low half, y in the high half.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic hit;
    logic idle;
  } cross_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAX,
    S_MAXW,
    S_RAY,
    S_EDGE,
    S_EDGEW,
    S_CLOSE,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// ----- sv/pip_if.sv -----
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channels of the point in polygon block: command in, result out.
// ----------------------------------------------------------------------------
interface pip_query_if;
  import pip_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [VIDX_BITS-1:0]        vertex_index;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  modport source (output valid, opcode, vertex_index, px, py, input ready);
  modport sink   (input valid, opcode, vertex_index, px, py, output ready);
endinterface

interface pip_result_if;
  import pip_pkg::*;

  logic                valid;
  logic                ready;
  logic                inside_res;
  logic [CNT_BITS-1:0] crossings;

  modport source (output valid, inside_res, crossings, input ready);
  modport sink   (input valid, inside_res, crossings, output ready);
endinterface

// ----- sv/pip_vertex_ram.sv -----
// ----------------------------------------------------------------------------
// pip_vertex_ram
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_vertex_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pip_pkg::IDX_BITS-1:0] waddr,
  input  pip_pkg::vertex_t             wdata,
  input  logic                         re,
  input  logic [pip_pkg::IDX_BITS-1:0] raddr,
  output pip_pkg::vertex_t             rdata
);
  import pip_pkg::*;

  vertex_t mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pip_cross_unit.sv -----
// ----------------------------------------------------------------------------
// pip_cross_unit
// Pipelined edge/ray intersection test, one edge accepted per cycle.
// ----------------------------------------------------------------------------
module pip_cross_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                edge_vld,
  input  pip_pkg::vertex_t                    edge_s,
  input  pip_pkg::vertex_t                    edge_e,
  input  pip_pkg::vertex_t                    q,
  input  logic signed [pip_pkg::RAY_BITS-1:0] bx,
  input  logic signed [pip_pkg::RAY_BITS-1:0] by,
  output pip_pkg::cross_stat_t                stat
);
  import pip_pkg::*;

  logic                        va, vb, vc, hit;
  logic signed [DIFF_BITS-1:0] ax, ay, dx, dy;
  logic signed [PROD_BITS-1:0] p_axby, p_aybx, p_dyax, p_dxay, p_dxby, p_dybx;
  logic signed [PROD_BITS-1:0] det, n1, n2;

  // The fraction n/det lies in [0,1], ends included.
  function automatic logic in_unit(input logic signed [PROD_BITS-1:0] n,
                                   input logic signed [PROD_BITS-1:0] d);
    logic r;
    if (d > 0) begin
      r = (n >= 0) && (n <= d);
    end else begin
      r = (n <= 0) && (n >= d);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb  <= 1'b0;
      vc  <= 1'b0;
      hit <= 1'b0;
    end else begin
      va  <= edge_vld;
      vb  <= va;
      vc  <= vb;
      hit <= vc && (det != 0) && in_unit(n1, det) && in_unit(n2, det);
    end
  end

  always_ff @(posedge clk) begin
    ax <= DIFF_BITS'(edge_e.x) - DIFF_BITS'(edge_s.x);
    ay <= DIFF_BITS'(edge_e.y) - DIFF_BITS'(edge_s.y);
    dx <= DIFF_BITS'(q.x) - DIFF_BITS'(edge_s.x);
    dy <= DIFF_BITS'(q.y) - DIFF_BITS'(edge_s.y);

    p_axby <= PROD_BITS'(ax * by);
    p_aybx <= PROD_BITS'(ay * bx);
    p_dyax <= PROD_BITS'(dy * ax);
    p_dxay <= PROD_BITS'(dx * ay);
    p_dxby <= PROD_BITS'(dx * by);
    p_dybx <= PROD_BITS'(dy * bx);

    det <= p_axby - p_aybx;
    n2  <= p_dyax - p_dxay;
    n1  <= p_dxby - p_dybx;
  end

  assign stat.hit  = hit;
  assign stat.idle = !(va || vb || vc || hit);

endmodule

// ----- sv/point_in_polygon_ray_crossing.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_ray_crossing
// Point in polygon test by counting polygon edges that cross a ray segment.
// ----------------------------------------------------------------------------
// A write item (opcode 0) stores one vertex at vertex_index and gives no
// result. A query item (opcode 1) gives a point. The block reads the
// vertices in use once to find the largest x and y, builds the ray from the
// point to (max x + 3, max y + 3), then reads them again and feeds each
// closed-polygon edge to a four-stage intersection pipeline. The result item
// carries the crossing count and its parity as the inside flag. Both passes
// over the vertices in use (vertex_count clamped to 3..64) go through the
// single read port of the vertex store. The block takes no new item while a
// query runs, but it does take the next item while a finished result still
// waits in the output register. vertex_count may be written whenever the
// block is idle. Vertices must be written before a query reads them; the
// store has no reset.
// ----------------------------------------------------------------------------
`include "point_in_polygon_ray_crossing_defines.svh"

module point_in_polygon_ray_crossing (
  input  logic                         clk,
  input  logic                         rst,
  pip_query_if.sink                    query,
  pip_result_if.source                 result,
  input  logic                         cfg_we,
  input  logic [pip_pkg::CNT_BITS-1:0] cfg_wdata
);
  import pip_pkg::*;

  state_t                      state, state_next;
  logic [CNT_BITS-1:0]         vcount;
  logic [IDX_BITS-1:0]         addr, last_idx, last_next;
  vertex_t                     q, rd_data, v0, prev, edge_e, wdata;
  logic                        rd_max, rd_edge, rd_first;
  logic signed [COORD_BITS-1:0] mx, my;
  logic signed [RAY_BITS-1:0]  bx, by;
  logic [CNT_BITS-1:0]         count;
  logic                        res_valid, res_inside;
  logic [CNT_BITS-1:0]         res_cross;
  cross_stat_t                 cstat;

  // Control decoded from the state and the command handshake.
  logic accept, query_go, ram_we, rd_en, close_edge, load, edge_vld;

  assign accept   = query.valid && query.ready;
  assign query_go = accept && (query.opcode == OP_QUERY);
  assign ram_we   = accept && (query.opcode == OP_WRITE) &&
                    (int'(query.vertex_index) < MAX_VERTICES);

  always_comb begin
    query.ready = 1'b0;
    rd_en       = 1'b0;
    close_edge  = 1'b0;
    load        = 1'b0;
    unique case (state)
      S_IDLE:  query.ready = 1'b1;
      S_MAX:   rd_en       = 1'b1;
      S_EDGE:  rd_en       = 1'b1;
      S_CLOSE: close_edge  = 1'b1;
      S_DONE:  load        = !res_valid || result.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (query_go) state_next = S_MAX;
      S_MAX:   if (addr == last_idx) state_next = S_MAXW;
      S_MAXW:  state_next = S_RAY;
      S_RAY:   state_next = S_EDGE;
      S_EDGE:  if (addr == last_idx) state_next = S_EDGEW;
      S_EDGEW: state_next = S_CLOSE;
      S_CLOSE: state_next = S_DRAIN;
      S_DRAIN: if (cstat.idle) state_next = S_DONE;
      S_DONE:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Last vertex slot in use, from the clamped vertex count.
  always_comb begin
    if (int'(vcount) < MIN_VERTICES) begin
      last_next = IDX_BITS'(MIN_VERTICES - 1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      last_next = IDX_BITS'(MAX_VERTICES - 1);
    end else begin
      last_next = IDX_BITS'(vcount - CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= CNT_BITS'(VCOUNT_RESET);
      addr      <= '0;
      last_idx  <= IDX_BITS'(MIN_VERTICES - 1);
      rd_max    <= 1'b0;
      rd_edge   <= 1'b0;
      rd_first  <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_max   <= rd_en && (state == S_MAX);
      rd_edge  <= rd_en && (state == S_EDGE);
      rd_first <= (addr == '0);
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (query_go) begin
        last_idx <= last_next;
        addr     <= '0;
      end else if (rd_en) begin
        addr <= (addr == last_idx) ? '0 : addr + IDX_BITS'(1);
      end
      if (query_go) begin
        count <= '0;
      end else if (cstat.hit) begin
        count <= count + CNT_BITS'(1);
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; control above decides when they matter.
  always_ff @(posedge clk) begin
    if (query_go) begin
      q.x <= query.px;
      q.y <= query.py;
    end
    if (rd_max) begin
      if (rd_first || (rd_data.x > mx)) mx <= rd_data.x;
      if (rd_first || (rd_data.y > my)) my <= rd_data.y;
    end
    if (state == S_RAY) begin
      bx <= RAY_BITS'(q.x) - (RAY_BITS'(mx) + RAY_BITS'(RAY_MARGIN));
      by <= RAY_BITS'(q.y) - (RAY_BITS'(my) + RAY_BITS'(RAY_MARGIN));
    end
    if (rd_edge) begin
      prev <= rd_data;
      if (rd_first) v0 <= rd_data;
    end
    if (load) begin
      res_cross  <= count;
      res_inside <= count[0];
    end
  end

  // Edges come from consecutive reads; the closing edge goes back to vertex 0.
  assign edge_vld = (rd_edge && !rd_first) || close_edge;
  assign edge_e   = close_edge ? v0 : rd_data;

  assign wdata.x = query.px;
  assign wdata.y = query.py;

  pip_vertex_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_BITS'(query.vertex_index)),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_data)
  );

  pip_cross_unit u_cross (
    .clk      (clk),
    .rst      (rst),
    .edge_vld (edge_vld),
    .edge_s   (prev),
    .edge_e   (edge_e),
    .q        (q),
    .bx       (bx),
    .by       (by),
    .stat     (cstat)
  );

  assign result.valid      = res_valid;
  assign result.inside_res = res_inside;
  assign result.crossings  = res_cross;

  // A result appears only when a finished query is unloaded.
  `PIP_ASSERT_NEXT(a_res_from_done, !res_valid && (state != S_DONE), !res_valid)
  // No more crossings than edges in the polygon.
  `PIP_ASSERT(a_count_bound, count <= (CNT_BITS'(last_idx) + CNT_BITS'(1)))
  // The intersection pipeline is empty whenever a new item can be taken.
  `PIP_ASSERT(a_idle_quiet, (state != S_IDLE) || cstat.idle)
  // The read pointer stays within the vertices in use during both passes.
  `PIP_ASSERT(a_addr_range, !rd_en || (addr <= last_idx))

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point in polygon ray crossing block. Vertices
// and query points go in on the command channel; every result is compared
// field by field with a hand-worked answer or with a predictor keeping its
// own copy of the vertex store and vertex_count. A short table of hand-picked
// items comes first, then random polygon phases, each under a fresh vertex_count.
// ----------------------------------------------------------------------------
module tb_top;
  import pip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run sizing. The settle wait covers a query over all 64 vertices with margin.
  localparam int ITEM_TARGET   = 1750;
  localparam int QUIET_FROM    = ITEM_TARGET - 200;
  localparam int SETTLE_CYCLES = 2 * MAX_VERTICES + 30;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  // One expected answer of a query.
  typedef struct packed {
    logic                odd;
    logic [CNT_BITS-1:0] hits;
  } crossing_result_t;

  // One row of the directed table. Where typed is set, want is the answer
  // worked out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    opcode_t                      op;
    logic [VIDX_BITS-1:0]         slot;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           typed;
    crossing_result_t             want;
  } stim_row_t;

  // The first triangle is (0,0) (10,0) (0,10), so the ray goes to (13,13).
  // From (2,2) it crosses only the slanted edge; from (13,13) it has zero
  // length. The extreme polygon sits on the corners of the coordinate range.
  // The last triangle has a vertical edge, a horizontal edge and a slanted
  // edge that lies on the diagonal ray from (-5,-5), which must not count.
  localparam stim_row_t DIR_ROWS [24] = '{
    '{OP_WRITE, 6'd0,  16'sd0,      16'sd0,      1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd1,  16'sd10,     16'sd0,      1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd2,  16'sd0,      16'sd10,     1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd2,      16'sd2,      1'b1, '{1'b1, 7'd1}},
    '{OP_QUERY, 6'd63, 16'sd13,     16'sd13,     1'b1, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd21, -16'sd20,    -16'sd20,    1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd42, 16'sh8000,   16'sh8000,   1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd63, 16'sh7FFF,   16'sh7FFF,   1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd0,      16'sd5,      1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd63, 16'sh7FFF,   16'sh8000,   1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd0,  16'sh8000,   16'sh8000,   1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd1,  16'sh7FFF,   16'sh8000,   1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd2,  16'sh7FFF,   16'sh7FFF,   1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd5,  16'sh8000,   16'sh7FFF,   1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd0,      16'sd0,      1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sh7FFF,   16'sh7FFF,   1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd0,  16'sd0,      16'sd0,      1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd1,  16'sd0,      16'sd20,     1'b0, '{1'b0, 7'd0}},
    '{OP_WRITE, 6'd2,  16'sd20,     16'sd20,     1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  -16'sd5,     -16'sd5,     1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  -16'sd5,     16'sd10,     1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd23,     16'sd23,     1'b1, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd25,     16'sd25,     1'b0, '{1'b0, 7'd0}},
    '{OP_QUERY, 6'd0,  16'sd0,      16'sd30,     1'b0, '{1'b0, 7'd0}}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CNT_BITS-1:0] cfg_wdata;

  pip_query_if  cmd_ch ();
  pip_result_if ans_ch ();

  point_in_polygon_ray_crossing u_top (
    .clk       (clk),
    .rst       (rst),
    .query     (cmd_ch),
    .result    (ans_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the polygon as the block should hold it, and the raw
  // vertex_count last written.
  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  logic [CNT_BITS-1:0]          vcount_reg;

  // Answers still owed by the block, oldest first.
  crossing_result_t pending_answers [$];

  // Shared between the command driver and the result sink.
  bit bursts_on;
  int hold_asked;
  int mismatches;

  // Figures for the closing summary.
  int items_sent;
  int writes_sent;
  int queries_sent;
  int results_seen;
  int inside_seen;
  int max_hits_seen;
  int long_holds;

  // Out-of-range counts are clamped to the legal span of polygon sizes.
  function automatic int vertices_in_use();
    int n;
    n = vcount_reg;
    if (n < MIN_VERTICES) n = MIN_VERTICES;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    return n;
  endfunction

  // Far end of the ray: the largest x and y over the vertices in use, plus
  // the margin. It may lie outside the 16-bit coordinate range.
  function automatic void ray_target(output longint ex, output longint ey);
    int n;
    n = vertices_in_use();
    ex = poly_x[0];
    ey = poly_y[0];
    for (int i = 1; i < n; i++) begin
      if (poly_x[i] > ex) ex = poly_x[i];
      if (poly_y[i] > ey) ey = poly_y[i];
    end
    ex += RAY_MARGIN;
    ey += RAY_MARGIN;
  endfunction

  // A Cramer numerator lies within [0,1] of the determinant, ends included.
  function automatic bit within_unit(longint num, longint det);
    if (det > 0) return (num >= 0) && (num <= det);
    return (num <= 0) && (num >= det);
  endfunction

  // Count the closed polygon's edges that cross the segment from the query
  // point to the ray target. A zero determinant means parallel lines and
  // never counts, collinear overlaps included.
  function automatic crossing_result_t predict_crossings(logic signed [COORD_BITS-1:0] qx,
                                                         logic signed [COORD_BITS-1:0] qy);
    int n;
    int nxt;
    int hits;
    longint ex, ey, ax, ay, bx, by, dx, dy, det, along_ray, along_edge;
    crossing_result_t ans;
    n = vertices_in_use();
    hits = 0;
    ray_target(ex, ey);
    bx = qx - ex;
    by = qy - ey;
    for (int i = 0; i < n; i++) begin
      nxt = (i + 1 < n) ? i + 1 : 0;
      ax = longint'(poly_x[nxt]) - poly_x[i];
      ay = longint'(poly_y[nxt]) - poly_y[i];
      dx = qx - longint'(poly_x[i]);
      dy = qy - longint'(poly_y[i]);
      det = ax * by - ay * bx;
      along_ray  = dy * ax - dx * ay;
      along_edge = dx * by - dy * bx;
      if (det != 0 && within_unit(along_edge, det) && within_unit(along_ray, det))
        hits++;
    end
    ans.hits = hits[CNT_BITS-1:0];
    ans.odd  = hits[0];
    return ans;
  endfunction

  // A coordinate within spread of center, clamped to the legal range. A
  // spread beyond the range means any 16-bit value at all.
  function automatic logic signed [COORD_BITS-1:0] pick_coord(int center, int spread);
    int v;
    if (spread > 32767) return COORD_BITS'($urandom);
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Offer one item and wait until it is taken. Valid is left high on
  // acceptance, so a back-to-back item keeps it high without a gap. The
  // predictor follows the item at the edge where it is taken.
  task automatic offer_item(input opcode_t op, input logic [VIDX_BITS-1:0] slot,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input bit typed, input crossing_result_t want);
    if (bursts_on && $urandom_range(3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.vertex_index <= slot;
    cmd_ch.px           <= x;
    cmd_ch.py           <= y;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    if (op == OP_WRITE) begin
      poly_x[slot] = x;
      poly_y[slot] = y;
      writes_sent++;
    end else begin
      pending_answers.push_back(typed ? want : predict_crossings(x, y));
      queries_sent++;
    end
  endtask

  // Stop offering, let every owed answer come back, then give a write that
  // may still be in flight, or a query that is running, time to finish.
  task automatic let_block_settle();
    cmd_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side. Each taken result is checked against the oldest answer
  // still owed. Ready follows three rules in order: a long hold-off when the
  // command side asks for one, short random stalls while bursts are on, and
  // otherwise always ready.
  initial begin : result_sink
    int hold_left;
    int hold_taken;
    int stall_left;
    crossing_result_t want;
    hold_left  = 0;
    hold_taken = 0;
    stall_left = 0;
    ans_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (ans_ch.valid && ans_ch.ready) begin
          results_seen++;
          if (pending_answers.size() == 0) begin
            report_mismatch("result with no query pending", ans_ch.crossings, -1);
          end else begin
            want = pending_answers.pop_front();
            if (ans_ch.inside_res !== want.odd)
              report_mismatch("inside_res", ans_ch.inside_res, want.odd);
            if (ans_ch.crossings !== want.hits)
              report_mismatch("crossings", ans_ch.crossings, want.hits);
            if (want.odd) inside_seen++;
            if (want.hits > max_hits_seen) max_hits_seen = want.hits;
          end
        end
        if (hold_left > 0) begin
          hold_left--;
          ans_ch.ready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
          // Long hold-off: the block should finish one query, park it in
          // the output register, take and run the next, then stall input.
          hold_taken = hold_asked;
          hold_left  = HOLD_CYCLES - 1;
          long_holds++;
          ans_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          ans_ch.ready <= 1'b0;
        end else if (bursts_on && $urandom_range(5) == 0) begin
          stall_left = $urandom_range(6, 1) - 1;
          ans_ch.ready <= 1'b0;
        end else begin
          ans_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Cycle watchdog for a hung handshake.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout with %0d answers pending", $realtime, pending_answers.size());
    $display("FAIL point_in_polygon_ray_crossing");
    $finish;
  end

  // Command side: reset, the directed table, then random polygon phases.
  initial begin : command_driver
    int first_counts [8];
    int phase;
    int n;
    int shape;
    int cx, cy, spread;
    int pick;
    int k;
    int raw_count;
    int raw_min, raw_max;
    longint ex, ey;
    logic signed [COORD_BITS-1:0] qx, qy;
    // The first phases walk the register's extremes, including values that
    // the block must clamp from below and from above.
    first_counts = '{3, 64, 0, 127, 2, 65, 1, 4};
    raw_min = 127;
    raw_max = 0;

    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_WRITE;
    cmd_ch.vertex_index <= '0;
    cmd_ch.px           <= '0;
    cmd_ch.py           <= '0;
    vcount_reg          = VCOUNT_RESET;
    bursts_on           = 1'b1;
    hold_asked          = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset vertex_count of three.
    foreach (DIR_ROWS[r])
      offer_item(DIR_ROWS[r].op, DIR_ROWS[r].slot, DIR_ROWS[r].x, DIR_ROWS[r].y,
                 DIR_ROWS[r].typed, DIR_ROWS[r].want);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // New vertex_count, written only once the block has gone quiet.
      let_block_settle();
      if (phase < 8) begin
        raw_count = first_counts[phase];
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      raw_count = $urandom_range(10, 3);
        else if (pick < 85) raw_count = $urandom_range(30, 11);
        else if (pick < 93) raw_count = MAX_VERTICES;
        else                raw_count = $urandom_range(127);
      end
      if (raw_count < raw_min) raw_min = raw_count;
      if (raw_count > raw_max) raw_max = raw_count;
      cfg_we    <= 1'b1;
      cfg_wdata <= raw_count[CNT_BITS-1:0];
      @(posedge clk);
      cfg_we    <= 1'b0;
      vcount_reg = raw_count[CNT_BITS-1:0];
      n = vertices_in_use();

      // Some phases run with no idling at all, and the tail of the run
      // never idles.
      bursts_on = (items_sent < QUIET_FROM) && ($urandom_range(3) != 0);

      // Polygon style: a tiny grid full of shared lines and vertex hits, a
      // small box somewhere in the plane, the whole range, or a cluster at
      // the top right where the ray target leaves the coordinate range.
      shape = $urandom_range(9);
      if (shape < 3) begin
        cx = 0; cy = 0; spread = 4;
      end else if (shape < 7) begin
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        spread = $urandom_range(300, 1);
      end else if (shape < 9) begin
        cx = 0; cy = 0; spread = 40000;
      end else begin
        cx = 32760; cy = 32760; spread = 12;
      end

      // Fill every slot in use before any query can read it.
      for (int i = 0; i < n; i++)
        offer_item(OP_WRITE, i[VIDX_BITS-1:0], pick_coord(cx, spread), pick_coord(cy, spread),
                   1'b0, '0);

      // Twice in the run, the result side holds off for a long stretch
      // while queries keep coming.
      if (phase == 1 || phase == 4) hold_asked++;

      repeat ($urandom_range(40, 15)) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          pick = $urandom_range(99);
          k = $urandom_range(n - 1);
          if (pick < 55) begin
            qx = pick_coord(cx, spread + spread / 4 + 2);
            qy = pick_coord(cy, spread + spread / 4 + 2);
          end else if (pick < 67) begin
            // Exactly on a vertex.
            qx = poly_x[k];
            qy = poly_y[k];
          end else if (pick < 77) begin
            // At the ray target, which gives a zero-length ray whenever the
            // target fits in the coordinate range.
            ray_target(ex, ey);
            qx = pick_coord(int'(ex), 0);
            qy = pick_coord(int'(ey), 0);
          end else if (pick < 87) begin
            qx = COORD_BITS'($urandom);
            qy = COORD_BITS'($urandom);
          end else begin
            // On the vertical line through a vertex.
            qx = poly_x[k];
            qy = pick_coord(poly_y[k], spread + 2);
          end
          offer_item(OP_QUERY, VIDX_BITS'($urandom), qx, qy, 1'b0, '0);
        end else if (pick < 88) begin
          k = $urandom_range(n - 1);
          offer_item(OP_WRITE, k[VIDX_BITS-1:0], pick_coord(cx, spread),
                     pick_coord(cy, spread), 1'b0, '0);
        end else begin
          // Any slot, any value; slots beyond the count in use are not read.
          offer_item(OP_WRITE, VIDX_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), 1'b0, '0);
        end
      end
      phase++;
    end

    bursts_on = 1'b0;
    let_block_settle();

    $display("Covered %0d vertex writes and %0d queries over %0d polygon phases,",
             writes_sent, queries_sent, phase);
    $display("vertex_count written from %0d to %0d, %0d results (%0d inside, max %0d), %0d holds.",
             raw_min, raw_max, results_seen, inside_seen, max_hits_seen, long_holds);
    if (mismatches == 0) begin
      $display("PASS point_in_polygon_ray_crossing");
    end else begin
      $display("FAIL point_in_polygon_ray_crossing");
    end
    $finish;
  end

endmodule

// ----- point_in_polygon_ray_crossing.f -----
+incdir+sv
sv/pip_pkg.sv
sv/pip_if.sv
sv/pip_vertex_ram.sv
sv/pip_cross_unit.sv
sv/point_in_polygon_ray_crossing.sv
tb/tb_top.sv
